// ===== design/mba_pkg.sv =====
// Shared types and constants for the multi-byte accumulator ALU.
// Depends on nothing; every design file refers to it by scoped names.
package mba_pkg;

	// Accumulator size in bytes, from 2 to 8.
	localparam int NUM_BYTES = 8;
	localparam int ACC_W     = 8 * NUM_BYTES;
	localparam int CNT_W     = $clog2(NUM_BYTES);
	localparam int VALUE_W   = 64;

	// Request action codes.
	localparam logic [2:0] ACT_SET   = 3'd0;
	localparam logic [2:0] ACT_CLEAR = 3'd1;
	localparam logic [2:0] ACT_ADD   = 3'd2;
	localparam logic [2:0] ACT_DEC   = 3'd3;
	localparam logic [2:0] ACT_MUL   = 3'd4;
	localparam logic [2:0] ACT_DIV   = 3'd5;

	// Operations of the shared byte unit.
	localparam logic [1:0] UOP_ADD = 2'd0;
	localparam logic [1:0] UOP_MUL = 2'd1;
	localparam logic [1:0] UOP_DIV = 2'd2;

	typedef struct packed {
		logic [2:0]  action;
		logic [63:0] operand_number;
		logic [7:0]  operand_byte;
	} cmd_t;

	typedef struct packed {
		logic [63:0] value;
		logic [7:0]  remainder;
		logic        nonzero;
		logic        divide_error;
	} rsp_t;

	// Control from the sequencer to the byte unit.
	typedef struct packed {
		logic [1:0] op;
		logic [7:0] factor;
	} unit_ctl_t;

endpackage

// ===== design/mba_byte_unit.sv =====
// Shared byte-wide arithmetic unit: add with carry, multiply-accumulate, and
// one 16-by-8 restoring division digit. Depends on mba_pkg.
module mba_byte_unit (
	input  mba_pkg::unit_ctl_t ctl,
	input  logic [7:0]         a,
	input  logic [7:0]         b,
	input  logic [7:0]         carry_in,
	output logic [7:0]         res,
	output logic [7:0]         carry_out
);

	logic [8:0]  sum;
	logic [15:0] prod;
	logic [8:0]  trial;
	logic [7:0]  rem;
	logic [7:0]  quo;

	assign sum  = 9'(a) + 9'(b) + 9'(carry_in[0]);
	assign prod = 16'(a) * 16'(ctl.factor) + 16'(carry_in);

	// The incoming remainder is below the divisor, so the quotient fits a byte.
	always_comb begin
		rem   = carry_in;
		quo   = '0;
		trial = '0;
		for (int k = 7; k >= 0; k--) begin
			trial = {rem, a[k]};
			if (trial >= 9'(ctl.factor)) begin
				trial  = trial - 9'(ctl.factor);
				quo[k] = 1'b1;
			end
			rem = trial[7:0];
		end
	end

	always_comb begin
		unique case (ctl.op)
			mba_pkg::UOP_ADD: begin
				res       = sum[7:0];
				carry_out = 8'(sum[8]);
			end
			mba_pkg::UOP_MUL: begin
				res       = prod[7:0];
				carry_out = prod[15:8];
			end
			mba_pkg::UOP_DIV: begin
				res       = quo;
				carry_out = rem;
			end
			default: begin
				res       = a;
				carry_out = '0;
			end
		endcase
	end

endmodule

// ===== design/multibyte_accumulator_alu.sv =====
// Top level of the multi-byte accumulator ALU: request sequencer, accumulator
// and result register. Depends on mba_pkg and mba_byte_unit.
//
// The block holds one unsigned accumulator of mba_pkg::NUM_BYTES bytes and
// applies one operation per request. A request beat is taken at a rising edge
// where start is high and busy is low. Set, clear, unused action codes and a
// divide by zero finish at once: the result beat follows in the next cycle and
// busy never rises. Add, decrement and multiply walk the accumulator from the
// least significant byte up, and divide walks it from the most significant
// byte down, one byte per cycle through a single shared byte unit; these run
// with busy high, and the result beat appears in the cycle after the last
// byte. The result beat is shown on rsp for exactly one cycle, marked by done,
// and the receiver cannot stall it, so it must capture the beat in that cycle.
// Since done and a low busy coincide, a new request can be issued in the same
// cycle as a result. Decrement is done as adding all ones; add, decrement and
// multiply wrap and drop the final carry. A divide by zero sets divide_error
// and keeps the accumulator. The accumulator clears on reset.
module multibyte_accumulator_alu (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  mba_pkg::cmd_t cmd,
	output logic          done,
	output mba_pkg::rsp_t rsp
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_RUN  = 1'b1;

	logic                      state_q;
	logic                      done_q;
	logic [mba_pkg::CNT_W-1:0] cnt_q;
	logic [mba_pkg::ACC_W-1:0] acc_q;
	logic [mba_pkg::ACC_W-1:0] num_q;
	logic [1:0]                uop_q;
	logic [7:0]                byte_q;
	logic [7:0]                carry_q;
	mba_pkg::rsp_t             rsp_q;

	logic                      accept;
	logic                      iterate;
	logic                      div_zero;
	logic                      last;
	logic                      lsb_first;
	logic [mba_pkg::ACC_W-1:0] acc_imm;
	logic [mba_pkg::ACC_W-1:0] acc_step;
	logic [mba_pkg::ACC_W-1:0] num_load;
	logic [1:0]                uop_load;
	mba_pkg::unit_ctl_t        unit_ctl;
	logic [7:0]                unit_a;
	logic [7:0]                unit_res;
	logic [7:0]                unit_carry;

	assign busy   = (state_q == S_RUN);
	assign accept = start && !busy;
	assign done   = done_q;
	assign rsp    = rsp_q;
	assign last   = (cnt_q == mba_pkg::CNT_W'(mba_pkg::NUM_BYTES - 1));

	// Decode of a new request: which ones run through the byte unit.
	always_comb begin
		div_zero = (cmd.action == mba_pkg::ACT_DIV) && (cmd.operand_byte == 8'd0);
		iterate  = 1'b0;
		uop_load = mba_pkg::UOP_ADD;
		num_load = cmd.operand_number[mba_pkg::ACC_W-1:0];
		acc_imm  = acc_q;
		unique case (cmd.action)
			mba_pkg::ACT_SET:   acc_imm = mba_pkg::ACC_W'(cmd.operand_byte);
			mba_pkg::ACT_CLEAR: acc_imm = '0;
			mba_pkg::ACT_ADD:   iterate = 1'b1;
			mba_pkg::ACT_DEC: begin
				iterate  = 1'b1;
				num_load = '1;
			end
			mba_pkg::ACT_MUL: begin
				iterate  = 1'b1;
				uop_load = mba_pkg::UOP_MUL;
			end
			mba_pkg::ACT_DIV: begin
				iterate  = !div_zero;
				uop_load = mba_pkg::UOP_DIV;
			end
			default: acc_imm = acc_q;
		endcase
	end

	// Byte selection: the accumulator rotates one byte per cycle, so the byte
	// under work is always at a fixed end of the register.
	assign lsb_first       = (uop_q != mba_pkg::UOP_DIV);
	assign unit_a          = lsb_first ? acc_q[7:0] : acc_q[mba_pkg::ACC_W-1 -: 8];
	assign unit_ctl.op     = uop_q;
	assign unit_ctl.factor = byte_q;
	assign acc_step        = lsb_first ? {unit_res, acc_q[mba_pkg::ACC_W-1:8]}
	                                   : {acc_q[mba_pkg::ACC_W-9:0], unit_res};

	mba_byte_unit u_unit (
		.ctl       (unit_ctl),
		.a         (unit_a),
		.b         (num_q[7:0]),
		.carry_in  (carry_q),
		.res       (unit_res),
		.carry_out (unit_carry)
	);

	// Control state and the accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			acc_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						if (iterate) begin
							state_q <= S_RUN;
						end else begin
							acc_q  <= acc_imm;
							done_q <= 1'b1;
						end
					end
				end
				S_RUN: begin
					acc_q <= acc_step;
					cnt_q <= cnt_q + 1'b1;
					if (last) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Operand shift register, carry and result beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			uop_q   <= uop_load;
			byte_q  <= cmd.operand_byte;
			num_q   <= num_load;
			carry_q <= '0;
			if (!iterate) begin
				rsp_q.value        <= mba_pkg::VALUE_W'(acc_imm);
				rsp_q.remainder    <= '0;
				rsp_q.nonzero      <= |acc_imm;
				rsp_q.divide_error <= div_zero;
			end
		end else if (busy) begin
			num_q   <= num_q >> 8;
			carry_q <= unit_carry;
			if (last) begin
				rsp_q.value        <= mba_pkg::VALUE_W'(acc_step);
				rsp_q.remainder    <= (uop_q == mba_pkg::UOP_DIV) ? unit_carry : 8'd0;
				rsp_q.nonzero      <= |acc_step;
				rsp_q.divide_error <= 1'b0;
			end
		end
	end

	// A result beat comes only from a request finished at once or the last byte step.
	a_done_source : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy ? last : accept))
		else $error("result beat without a finished request");

	// The byte counter steps by one on every cycle of an iterative request.
	a_cnt_step : assert property (@(posedge clk) disable iff (!arst_n)
		(busy && !last) |=> (busy && cnt_q == $past(cnt_q) + 1'b1))
		else $error("byte counter did not advance");

	// A divide by zero leaves the accumulator as it was.
	a_div_zero_keep : assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.divide_error) |-> ($stable(acc_q) && rsp.remainder == 8'd0))
		else $error("divide by zero changed the accumulator");

	// The nonzero flag agrees with the reported value.
	a_nonzero : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.nonzero == (rsp.value != '0)))
		else $error("nonzero flag disagrees with value");

endmodule

// ===== dv/mba_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the multi-byte accumulator ALU: keeps its own copy of the
// accumulator, predicts every result beat and compares it field by field.
// Depends on mba_pkg for the request and result types and the action codes.
module mba_result_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  mba_pkg::cmd_t cmd,
	input  logic          done,
	input  mba_pkg::rsp_t rsp,
	output int            fail_count,
	output int            pending,
	output int            results_checked
);

	typedef struct {
		logic [2:0]    action;
		mba_pkg::rsp_t rsp;
	} predicted_t;

	logic [mba_pkg::ACC_W-1:0] acc_copy;
	predicted_t                predicted_rsp_q[$];

	// Applies one request to the local accumulator copy and returns the
	// result beat it should produce.
	function automatic mba_pkg::rsp_t accumulate_step(input mba_pkg::cmd_t c);
		mba_pkg::rsp_t r;
		r = '0;
		case (c.action)
			mba_pkg::ACT_SET:   acc_copy = mba_pkg::ACC_W'(c.operand_byte);
			mba_pkg::ACT_CLEAR: acc_copy = '0;
			mba_pkg::ACT_ADD:   acc_copy = acc_copy + c.operand_number[mba_pkg::ACC_W-1:0];
			mba_pkg::ACT_DEC:   acc_copy = acc_copy - 1'b1;
			mba_pkg::ACT_MUL:   acc_copy = acc_copy * mba_pkg::ACC_W'(c.operand_byte);
			mba_pkg::ACT_DIV: begin
				// Byte-by-byte long division gives the plain quotient and remainder.
				if (c.operand_byte == 8'd0) begin
					r.divide_error = 1'b1;
				end else begin
					r.remainder = 8'(acc_copy % mba_pkg::ACC_W'(c.operand_byte));
					acc_copy    = acc_copy / mba_pkg::ACC_W'(c.operand_byte);
				end
			end
			default: ;
		endcase
		r.value[mba_pkg::ACC_W-1:0] = acc_copy;
		r.nonzero                   = (acc_copy != '0);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		predicted_t p;
		if (!arst_n) begin
			acc_copy = '0;
			predicted_rsp_q.delete();
			pending         <= 0;
			fail_count      <= 0;
			results_checked <= 0;
		end else begin
			// A result beat always belongs to a request taken at an earlier edge,
			// so it is matched before this edge's request is queued.
			if (done) begin
				if (predicted_rsp_q.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: result beat with nothing expected: value %h", $realtime,
							rsp.value);
					fail_count <= fail_count + 1;
				end else begin
					p = predicted_rsp_q.pop_front();
					results_checked <= results_checked + 1;
					if (rsp.value !== p.rsp.value || rsp.remainder !== p.rsp.remainder ||
					    rsp.nonzero !== p.rsp.nonzero ||
					    rsp.divide_error !== p.rsp.divide_error) begin
						if (fail_count < 10) begin
							$write("%0t: action %0d expected value %h rem %h nz %b err %b,",
								$realtime, p.action, p.rsp.value, p.rsp.remainder,
								p.rsp.nonzero, p.rsp.divide_error);
							$display(" got value %h rem %h nz %b err %b", rsp.value,
								rsp.remainder, rsp.nonzero, rsp.divide_error);
						end
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy) begin
				p.action = cmd.action;
				p.rsp    = accumulate_step(cmd);
				predicted_rsp_q.push_back(p);
			end
			pending <= predicted_rsp_q.size();
		end
	end

endmodule

// ===== dv/tb_multibyte_accumulator_alu.sv =====
`timescale 1ns / 1ps
// Testbench top for the multi-byte accumulator ALU: clock, reset, request
// stimulus and the verdict. Depends on mba_pkg, multibyte_accumulator_alu and
// mba_result_checker.
module tb_multibyte_accumulator_alu;

	// Longest correct stretch without a beat is a sender gap plus one full
	// byte walk; this limit is many times that, including the drain pauses.
	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_ITEMS = 2000;

	// Action codes that have no operation assigned.
	localparam logic [2:0] ACT_NOP_LO = 3'd6;
	localparam logic [2:0] ACT_NOP_HI = 3'd7;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	mba_pkg::cmd_t cmd;
	logic          done;
	mba_pkg::rsp_t rsp;

	int fail_count;
	int pending;
	int results_checked;
	int idle_cycles = 0;
	int issued_per_action[8];
	int div_by_zero;

	multibyte_accumulator_alu u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.rsp    (rsp)
	);

	mba_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.cmd             (cmd),
		.done            (done),
		.rsp             (rsp),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The watchdog restarts on every request or result beat, so it only fires
	// when the block has stopped making progress.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Watchdog: no beat for %0d cycles, %0d results outstanding",
					IDLE_LIMIT, pending);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// Presents one request and holds it until the block takes it. Called at a
	// rising edge, and returns at the edge where the beat was accepted, so a
	// back-to-back request keeps start high without lowering it in between.
	task automatic issue_cmd(input logic [2:0] act, input logic [63:0] num,
	                         input logic [7:0] operand);
		mba_pkg::cmd_t c;
		c.action         = act;
		c.operand_number = num;
		c.operand_byte   = operand;
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		issued_per_action[act]++;
		if (act == mba_pkg::ACT_DIV && operand == 8'd0)
			div_by_zero++;
	endtask

	task automatic hold_off(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Stops sending until the checker has seen every outstanding result. The
	// first edge lets the count of outstanding results catch up.
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		int burst_left;
		int pick;
		logic [2:0]  act;
		logic [63:0] num;
		logic [7:0]  operand;

		start       <= 1'b0;
		cmd         <= '0;
		arst_n      = 1'b0;
		div_by_zero = 0;
		foreach (issued_per_action[i]) issued_per_action[i] = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: byte and number extremes, every action, the unused
		// codes, wrap on add, decrement and multiply, and the zero divisor.
		issue_cmd(mba_pkg::ACT_DEC,   64'd0, 8'd0);     // decrement below zero wraps
		issue_cmd(mba_pkg::ACT_ADD,   64'd1, 8'd0);     // and back to zero by overflow
		issue_cmd(mba_pkg::ACT_ADD,   '1,    8'hFF);
		issue_cmd(mba_pkg::ACT_ADD,   '1,    8'd0);     // add overflow drops the carry
		issue_cmd(mba_pkg::ACT_MUL,   64'd0, 8'hFF);    // multiply overflow wraps
		issue_cmd(mba_pkg::ACT_DIV,   64'd0, 8'd0);     // zero divisor keeps the value
		issue_cmd(mba_pkg::ACT_DIV,   64'd0, 8'hFF);
		issue_cmd(mba_pkg::ACT_DIV,   64'd0, 8'd1);
		issue_cmd(mba_pkg::ACT_DIV,   64'd0, 8'd7);
		issue_cmd(ACT_NOP_LO,         '1,    8'hFF);    // unused codes do nothing
		issue_cmd(ACT_NOP_HI,         64'd0, 8'd0);
		issue_cmd(mba_pkg::ACT_SET,   '1,    8'hFF);
		issue_cmd(mba_pkg::ACT_MUL,   64'd0, 8'd0);     // multiply by zero
		issue_cmd(mba_pkg::ACT_SET,   64'd0, 8'd1);
		issue_cmd(mba_pkg::ACT_DEC,   '1,    8'hFF);    // decrement down to zero
		issue_cmd(mba_pkg::ACT_DIV,   64'd0, 8'd3);     // zero divided, nothing left
		issue_cmd(mba_pkg::ACT_SET,   64'd0, 8'd0);
		issue_cmd(mba_pkg::ACT_CLEAR, '1,    8'hFF);
		issue_cmd(mba_pkg::ACT_ADD,   64'h8000_0000_0000_0000, 8'd0);
		issue_cmd(mba_pkg::ACT_MUL,   64'd0, 8'd2);     // top bit shifts out
		issue_cmd(mba_pkg::ACT_ADD,   64'h0123_4567_89AB_CDEF, 8'd0);
		issue_cmd(mba_pkg::ACT_DIV,   64'd0, 8'd16);
		issue_cmd(mba_pkg::ACT_CLEAR, 64'd0, 8'd0);
		drain_results();

		// Random part in bursts. Multiplies and adds push the value up, divides
		// and clears pull it back, so both large and zero values keep showing.
		burst_left = $urandom_range(1, 30);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 10)      act = mba_pkg::ACT_SET;
			else if (pick < 15) act = mba_pkg::ACT_CLEAR;
			else if (pick < 38) act = mba_pkg::ACT_ADD;
			else if (pick < 52) act = mba_pkg::ACT_DEC;
			else if (pick < 72) act = mba_pkg::ACT_MUL;
			else if (pick < 95) act = mba_pkg::ACT_DIV;
			else                act = 3'($urandom_range(ACT_NOP_LO, ACT_NOP_HI));

			case ($urandom_range(0, 7))
				0:       num = '0;
				1:       num = '1;
				2:       num = 64'($urandom_range(0, 255));
				default: num = {$urandom, $urandom};
			endcase

			case ($urandom_range(0, 9))
				0:       operand = 8'd0;
				1:       operand = 8'hFF;
				2:       operand = 8'd1;
				default: operand = 8'($urandom_range(0, 255));
			endcase

			issue_cmd(act, num, operand);

			if ($urandom_range(0, 299) == 0) begin
				drain_results();
			end else if (--burst_left == 0) begin
				// A few bursts run straight into the next one with no gap.
				if ($urandom_range(0, 3) != 0)
					hold_off($urandom_range(1, 10));
				burst_left = $urandom_range(1, 30);
			end
		end

		drain_results();
		repeat (2 * mba_pkg::NUM_BYTES + 4) @(posedge clk);

		$write("Run covered %0d set, %0d clear, %0d add, %0d decrement, %0d multiply",
			issued_per_action[mba_pkg::ACT_SET], issued_per_action[mba_pkg::ACT_CLEAR],
			issued_per_action[mba_pkg::ACT_ADD], issued_per_action[mba_pkg::ACT_DEC],
			issued_per_action[mba_pkg::ACT_MUL]);
		$display(" and %0d divide beats (%0d by zero), %0d with unused codes.",
			issued_per_action[mba_pkg::ACT_DIV], div_by_zero,
			issued_per_action[ACT_NOP_LO] + issued_per_action[ACT_NOP_HI]);
		$display("%0d result beats compared, %0d mismatches.", results_checked, fail_count);
		if (fail_count == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
